FILE: hdl/jnfp_pkg.sv
`default_nettype none

package jnfp_pkg;

	localparam int MAX_NAME_LEN_DEF = 256;

	typedef enum logic [3:0] {
		PH_AT      = 4'd0,
		PH_TAI     = 4'd1,
		PH_ID      = 4'd2,
		PH_LATE    = 4'd3,
		PH_REPEATS = 4'd4,
		PH_CRON    = 4'd5,
		PH_COMMENT = 4'd6,
		PH_FLAGS   = 4'd7,
		PH_FROM    = 4'd8,
		PH_TO      = 4'd9,
		PH_EVERY   = 4'd10,
		PH_DONE    = 4'd11
	} phase_t;

	localparam logic [3:0] KIND_NONE    = 4'd0;
	localparam logic [3:0] KIND_TAI     = 4'd1;
	localparam logic [3:0] KIND_LATE    = 4'd3;
	localparam logic [3:0] KIND_REPEATS = 4'd4;
	localparam logic [3:0] KIND_EVERY   = 4'd10;

	localparam logic [1:0] VERDICT_RECORD = 2'd0;
	localparam logic [1:0] VERDICT_ACCEPT = 2'd1;
	localparam logic [1:0] VERDICT_REJECT = 2'd2;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [4:0] TAI_DIGITS = 5'd16;

	localparam logic [2:0] FLAG_LIT_LEN = 3'd4;
	localparam logic [2:0] FLAG_NULL1   = 3'd5;
	localparam logic [2:0] FLAG_NULL2   = 3'd6;
	localparam logic [2:0] FLAG_BAD     = 3'd7;
	localparam logic [2:0] FLAG_LEN_MAX = 3'd7;

	// largest accumulator that still takes another decimal digit
	localparam logic [63:0] DEC_LIMIT       = 64'd1844674407370955161;
	localparam logic [3:0]  DEC_LIMIT_DIGIT = 4'd5;

	typedef struct packed {
		phase_t      phase;
		logic [63:0] acc;
		logic [4:0]  hex;
		logic [2:0]  prog;
		logic [2:0]  flen;
		logic        n1;
		logic        n2;
		logic        err;
		logic        ign;
	} st_t;

	localparam st_t ST_RESET = '{
		phase: PH_AT, acc: 64'd0, hex: 5'd0, prog: 3'd0, flen: 3'd0,
		n1: 1'b0, n2: 1'b0, err: 1'b0, ign: 1'b0
	};

	typedef struct packed {
		logic        valid;
		logic [3:0]  kind;
		logic [7:0]  start;
		logic [7:0]  len;
		logic [63:0] num;
	} rec_t;

	typedef struct packed {
		logic [3:0]  field_kind;
		logic [7:0]  field_start;
		logic [7:0]  field_length;
		logic [63:0] field_number;
		logic        flag_null_one;
		logic        flag_null_two;
		logic [1:0]  verdict;
		logic        final_result;
	} res_t;

	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		logic       ok;
		v  = 8'd0;
		ok = 1'b0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			v  = c - CH_ZERO;
			ok = 1'b1;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v  = c - 8'h57;
			ok = 1'b1;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v  = c - 8'h37;
			ok = 1'b1;
		end
		return {ok, v[3:0]};
	endfunction

	function automatic logic [7:0] null_char(input logic [1:0] n);
		logic [7:0] ch;
		case (n)
			2'd0: ch = 8'h6e;
			2'd1: ch = 8'h75;
			default: ch = 8'h6c;
		endcase
		return ch;
	endfunction

	function automatic phase_t next_phase(input phase_t p);
		phase_t q;
		case (p)
			PH_LATE:    q = PH_REPEATS;
			PH_REPEATS: q = PH_CRON;
			PH_CRON:    q = PH_COMMENT;
			PH_COMMENT: q = PH_FLAGS;
			PH_FLAGS:   q = PH_FROM;
			PH_FROM:    q = PH_TO;
			PH_TO:      q = PH_EVERY;
			default:    q = p;
		endcase
		return q;
	endfunction

	function automatic logic is_number_kind(input phase_t p);
		return (p == PH_TAI) || (p == PH_LATE) || (p == PH_REPEATS) || (p == PH_EVERY);
	endfunction

	function automatic st_t clear_field(input st_t s);
		st_t r;
		r      = s;
		r.acc  = 64'd0;
		r.hex  = 5'd0;
		r.prog = 3'd0;
		r.flen = 3'd0;
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/jnfp_if.sv
`default_nettype none

interface jnfp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] name_byte;
	logic       end_of_name;

	modport source (output valid, output name_byte, output end_of_name, input ready);
	modport sink (input valid, input name_byte, input end_of_name, output ready);
endinterface

interface jnfp_rec_if;
	logic        valid;
	logic        ready;
	logic [3:0]  field_kind;
	logic [7:0]  field_start;
	logic [7:0]  field_length;
	logic [63:0] field_number;
	logic        flag_null_one;
	logic        flag_null_two;
	logic [1:0]  verdict;
	logic        final_result;

	modport source (
		output valid, output field_kind, output field_start, output field_length,
		output field_number, output flag_null_one, output flag_null_two,
		output verdict, output final_result, input ready
	);
	modport sink (
		input valid, input field_kind, input field_start, input field_length,
		input field_number, input flag_null_one, input flag_null_two,
		input verdict, input final_result, output ready
	);
endinterface

`default_nettype wire

FILE: hdl/job_name_field_parser.sv
`default_nettype none

// Job name parser: takes one character request per cycle on chars and checks a
// name of the form @tai:id:late:repeats:cron:comment:flags[:from:to[:every]].
// Each field gives one record on records as it closes, unless the name has
// an error by then; the byte marked end_of_name always gives the closing result
// with the verdict, after which the parser is back in its reset state. A
// character passes an input register and the combinational parse logic into
// the result register, from which any result it gives goes out on records. One
// character is taken every cycle while records is ready; a result held on
// records stalls chars as soon as the input register is full.
// Names longer than MAX_NAME_LEN bytes are rejected.

module job_name_field_parser
	import jnfp_pkg::*;
#(
	parameter int MAX_NAME_LEN = MAX_NAME_LEN_DEF
) (
	input wire logic     clk,
	input wire logic     arst_n,
	jnfp_char_if.sink    chars,
	jnfp_rec_if.source   records
);

	localparam int PW_RAW = $clog2(MAX_NAME_LEN + 2);
	localparam int PW     = (PW_RAW > 8) ? PW_RAW : 8;

	logic          valid_s1;
	logic [7:0]    name_byte_s1;
	logic          end_of_name_s1;
	st_t           st_q;
	logic [PW-1:0] pos_q;
	logic [PW-1:0] start_q;
	logic          res_valid_q;
	res_t          res_q;

	st_t           nst;
	logic [PW-1:0] npos;
	logic [PW-1:0] nstart;
	logic          emit;
	res_t          res;
	logic          advance;

	assign advance     = valid_s1 && (!res_valid_q || records.ready);
	assign chars.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			name_byte_s1   <= chars.name_byte;
			end_of_name_s1 <= chars.end_of_name;
		end
	end

	jnfp_step #(
		.MAX_NAME_LEN(MAX_NAME_LEN),
		.PW(PW)
	) u_step (
		.name_byte(name_byte_s1),
		.end_of_name(end_of_name_s1),
		.st(st_q),
		.pos(pos_q),
		.start(start_q),
		.nst(nst),
		.npos(npos),
		.nstart(nstart),
		.emit(emit),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_RESET;
			pos_q       <= '0;
			start_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				st_q        <= nst;
				pos_q       <= npos;
				start_q     <= nstart;
				res_valid_q <= emit;
			end else if (records.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res;
		end
	end

	assign records.valid         = res_valid_q;
	assign records.field_kind    = res_q.field_kind;
	assign records.field_start   = res_q.field_start;
	assign records.field_length  = res_q.field_length;
	assign records.field_number  = res_q.field_number;
	assign records.flag_null_one = res_q.flag_null_one;
	assign records.flag_null_two = res_q.flag_null_two;
	assign records.verdict       = res_q.verdict;
	assign records.final_result  = res_q.final_result;

endmodule

`default_nettype wire

FILE: hdl/jnfp_step.sv
`default_nettype none

module jnfp_step
	import jnfp_pkg::*;
#(
	parameter int MAX_NAME_LEN = MAX_NAME_LEN_DEF,
	parameter int PW = 9
) (
	input  wire logic [7:0]    name_byte,
	input  wire logic          end_of_name,
	input  wire st_t           st,
	input  wire logic [PW-1:0] pos,
	input  wire logic [PW-1:0] start,
	output st_t                nst,
	output logic [PW-1:0]      npos,
	output logic [PW-1:0]      nstart,
	output logic               emit,
	output res_t               res
);

	localparam logic [PW-1:0] MAX_POS = PW'(MAX_NAME_LEN);
	localparam logic [PW-1:0] ONE     = PW'(1);

	function automatic rec_t make_rec(input phase_t k, input logic [PW-1:0] s,
			input logic [PW-1:0] e, input logic [63:0] a);
		rec_t        r;
		logic [PW-1:0] d;
		d       = e - s;
		r.valid = 1'b1;
		r.kind  = k;
		r.start = s[7:0];
		r.len   = d[7:0];
		r.num   = is_number_kind(k) ? a : 64'd0;
		return r;
	endfunction

	logic [4:0]  hv;
	logic [3:0]  dig;
	logic [63:0] acc10;
	logic        dec_sat;
	logic        flag_ok;
	rec_t        rec;

	assign hv      = hex_val(name_byte);
	assign dig     = name_byte[3:0];
	assign acc10   = {st.acc[60:0], 3'b000} + {st.acc[62:0], 1'b0} + {60'd0, dig};
	assign dec_sat = (st.acc > DEC_LIMIT) || (st.acc == DEC_LIMIT && dig > DEC_LIMIT_DIGIT);

	always_comb begin
		nst     = st;
		npos    = pos;
		nstart  = start;
		rec     = '0;
		flag_ok = 1'b0;
		if (st.phase != PH_DONE) begin
			if (name_byte != CH_NUL) begin
				if (pos <= MAX_POS) begin
					npos = pos + ONE;
				end
				if (npos > MAX_POS) begin
					nst.err = 1'b1;
				end
				if (!nst.err && !st.ign) begin
					case (st.phase)
						PH_AT: begin
							if (name_byte == CH_AT) begin
								nst.phase = PH_TAI;
								nstart    = pos + ONE;
								nst.acc   = 64'd0;
								nst.hex   = 5'd0;
							end else begin
								nst.err = 1'b1;
							end
						end
						PH_TAI: begin
							if (hv[4] && st.hex < TAI_DIGITS) begin
								nst.acc = {st.acc[59:0], hv[3:0]};
								nst.hex = st.hex + 5'd1;
							end else if (name_byte == CH_COLON && st.hex == TAI_DIGITS) begin
								rec       = make_rec(PH_TAI, start, pos, st.acc);
								nst       = clear_field(nst);
								nstart    = pos + ONE;
								nst.phase = PH_ID;
							end else begin
								nst.err = 1'b1;
							end
						end
						PH_ID: begin
							if (name_byte == CH_COLON) begin
								if (pos == start) begin
									nst.err = 1'b1;
								end else begin
									rec       = make_rec(PH_ID, start, pos, st.acc);
									nst       = clear_field(nst);
									nstart    = pos + ONE;
									nst.phase = PH_LATE;
								end
							end
						end
						PH_LATE, PH_REPEATS, PH_EVERY: begin
							if (name_byte >= CH_ZERO && name_byte <= CH_NINE) begin
								nst.acc = dec_sat ? '1 : acc10;
							end else if (name_byte == CH_COLON) begin
								rec    = make_rec(st.phase, start, pos, st.acc);
								nst    = clear_field(nst);
								nstart = pos + ONE;
								if (st.phase == PH_EVERY) begin
									nst.ign = 1'b1;
								end else begin
									nst.phase = next_phase(st.phase);
								end
							end else begin
								nst.err = 1'b1;
							end
						end
						PH_CRON, PH_COMMENT, PH_FROM, PH_TO: begin
							if (name_byte == CH_COLON) begin
								rec       = make_rec(st.phase, start, pos, st.acc);
								nst       = clear_field(nst);
								nstart    = pos + ONE;
								nst.phase = next_phase(st.phase);
							end
						end
						PH_FLAGS: begin
							flag_ok = (st.prog == FLAG_NULL1) || (st.prog == FLAG_NULL2);
							if (name_byte == CH_COMMA) begin
								if (st.flen == 3'd0 || !flag_ok) begin
									nst.err = 1'b1;
								end else begin
									nst.n1   = st.n1 | (st.prog == FLAG_NULL1);
									nst.n2   = st.n2 | (st.prog == FLAG_NULL2);
									nst.prog = 3'd0;
									nst.flen = 3'd0;
								end
							end else if (name_byte == CH_COLON) begin
								if (st.flen != 3'd0 && !flag_ok) begin
									nst.err = 1'b1;
								end else begin
									if (st.flen != 3'd0) begin
										nst.n1 = st.n1 | (st.prog == FLAG_NULL1);
										nst.n2 = st.n2 | (st.prog == FLAG_NULL2);
									end
									rec       = make_rec(PH_FLAGS, start, pos, st.acc);
									nst       = clear_field(nst);
									nstart    = pos + ONE;
									nst.phase = PH_FROM;
								end
							end else begin
								if (st.flen < FLAG_LIT_LEN && st.prog == st.flen
										&& name_byte == null_char(st.flen[1:0])) begin
									nst.prog = st.flen + 3'd1;
								end else if (st.flen == FLAG_LIT_LEN && st.prog == FLAG_LIT_LEN
										&& name_byte == CH_ONE) begin
									nst.prog = FLAG_NULL1;
								end else if (st.flen == FLAG_LIT_LEN && st.prog == FLAG_LIT_LEN
										&& name_byte == CH_TWO) begin
									nst.prog = FLAG_NULL2;
								end else begin
									nst.prog = FLAG_BAD;
								end
								if (st.flen < FLAG_LEN_MAX) begin
									nst.flen = st.flen + 3'd1;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			// end of the name text
			if (name_byte == CH_NUL || end_of_name) begin
				if (!nst.err && !nst.ign) begin
					case (nst.phase)
						PH_FLAGS: begin
							if (nst.flen != 3'd0 && !(nst.prog == FLAG_NULL1
									|| nst.prog == FLAG_NULL2)) begin
								nst.err = 1'b1;
							end else begin
								if (nst.flen != 3'd0) begin
									nst.n1 = nst.n1 | (nst.prog == FLAG_NULL1);
									nst.n2 = nst.n2 | (nst.prog == FLAG_NULL2);
								end
								rec    = make_rec(PH_FLAGS, nstart, npos, nst.acc);
								nst    = clear_field(nst);
								nstart = npos + ONE;
							end
						end
						PH_TO, PH_EVERY: begin
							rec    = make_rec(nst.phase, nstart, npos, nst.acc);
							nst    = clear_field(nst);
							nstart = npos + ONE;
						end
						default: begin
							nst.err = 1'b1;
						end
					endcase
				end
				nst.phase = PH_DONE;
			end
		end
		if (nst.err) begin
			rec = '0;
		end

		emit              = end_of_name || rec.valid;
		res.field_kind    = rec.valid ? rec.kind : KIND_NONE;
		res.field_start   = rec.start;
		res.field_length  = rec.len;
		res.field_number  = rec.num;
		res.flag_null_one = nst.n1;
		res.flag_null_two = nst.n2;
		res.verdict       = !end_of_name ? VERDICT_RECORD
			: (nst.err ? VERDICT_REJECT : VERDICT_ACCEPT);
		res.final_result  = end_of_name;

		if (end_of_name) begin
			nst    = ST_RESET;
			npos   = '0;
			nstart = '0;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/jnfp_checker.sv
`default_nettype none

module jnfp_checker
	import jnfp_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        rec_valid,
	input wire logic        rec_ready,
	input wire logic [3:0]  field_kind,
	input wire logic [63:0] field_number,
	input wire logic [1:0]  verdict,
	input wire logic        final_result
);

	// stalled request keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && !rec_ready |=> rec_valid && $stable(field_kind)
			&& $stable(field_number) && $stable(verdict) && $stable(final_result))
		else $error("stalled result changed");

	// closing result carries a verdict, a field record does not
	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid |-> (final_result == (verdict != VERDICT_RECORD))
			&& verdict != 2'd3)
		else $error("verdict does not match final flag");

	// a record that is not the closing one names a field
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && !final_result |-> field_kind != KIND_NONE)
		else $error("field record without a field");

	// only numeric fields carry a value
	a_number: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && field_kind != KIND_TAI && field_kind != KIND_LATE
			&& field_kind != KIND_REPEATS && field_kind != KIND_EVERY
			|-> field_number == 64'd0)
		else $error("non-numeric field with a value");

	// a rejected name reports no field
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && verdict == VERDICT_REJECT |-> field_kind == KIND_NONE)
		else $error("rejected name with a field record");

endmodule

bind job_name_field_parser jnfp_checker u_jnfp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.rec_valid(records.valid),
	.rec_ready(records.ready),
	.field_kind(records.field_kind),
	.field_number(records.field_number),
	.verdict(records.verdict),
	.final_result(records.final_result)
);

`default_nettype wire
